/* hdl/assert_macros.svh */
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define PCX_ASSERT(label, clk, rstn, prop) \
    label: assert property (@(posedge clk) disable iff (!rstn) prop) \
        else $error("pcx checker: property failed");

// Checked at every clock edge, reset included.
`define PCX_ASSERT_ALWAYS(label, clk, prop) \
    label: assert property (@(posedge clk) prop) \
        else $error("pcx checker: property failed");

`endif

/* hdl/pcxrle_pkg.sv */
`timescale 1ns / 1ps

package pcxrle_pkg;

    localparam int PALETTE_DEPTH = 256;
    localparam int DIM_BITS      = 16;
    localparam int PAL_AW        = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
    localparam int RUN_W         = 6;
    localparam int CFG_W         = DIM_BITS + 1;
    localparam int IN_DATA_W     = 40;
    localparam int OUT_DATA_W    = 40;

    localparam logic [8:0] PAL_DEPTH_W  = 9'(PALETTE_DEPTH);
    localparam logic [7:0] MARK_BITS    = 8'hC0;
    localparam logic [7:0] COUNT_BITS   = 8'h3F;
    localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
    localparam logic [7:0] ALPHA_CLEAR  = 8'd0;

    localparam logic OP_IMAGE   = 1'b0;
    localparam logic OP_PALETTE = 1'b1;

    localparam logic [1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [1:0] CFG_IMAGE_HEIGHT = 2'd1;
    localparam logic [1:0] CFG_LINE_STRIDE  = 2'd2;
    localparam logic [1:0] CFG_TRANSPARENT  = 2'd3;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_FIN
    } pcxrle_state_t;

    typedef struct packed {
        logic pal_we;       // palette entry write from the input item
        logic place_en;     // place one decoded index
        logic sel_run;      // index comes from the held run value
        logic status_en;    // issue short-stream status result
        logic clear_pos;    // return position and run state to reset
        logic set_pending;  // latch a run marker
        logic clr_pending;  // drop the pending marker
        logic load_run;     // start draining a run
        logic dec_run;      // one run pixel done
    } pcxrle_cmd_t;

    typedef struct packed {
        logic issue_ok;     // lookup stage can take a new result
        logic full;         // image complete
        logic pending;      // run marker waiting for its value byte
        logic len_zero;     // pending run has count zero
        logic marker;       // input byte has both top bits set
        logic run_last;     // last pixel of the run being drained
    } pcxrle_stat_t;

endpackage

/* hdl/pcxrle_ram.sv */
`timescale 1ns / 1ps

module pcxrle_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 256
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

/* hdl/pcxrle_ctrl.sv */
`timescale 1ns / 1ps

module pcxrle_ctrl
    import pcxrle_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    input  logic         s_axis_tlast,
    input  logic         s_axis_tuser,
    input  pcxrle_stat_t stat,
    output pcxrle_cmd_t  cmd
);

    pcxrle_state_t state_reg, state_next;
    logic          fin_reg, fin_next;
    logic          accept;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            fin_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        fin_next      = fin_reg;
        cmd           = '0;
        s_axis_tready = 1'b0;
        accept        = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = stat.issue_ok;
                accept        = s_axis_tvalid && stat.issue_ok;
                if (accept) begin
                    if (s_axis_tuser == OP_PALETTE) begin
                        cmd.pal_we = 1'b1;
                    end else begin
                        if (!stat.full) begin
                            if (stat.pending) begin
                                cmd.clr_pending = 1'b1;
                                if (!stat.len_zero) begin
                                    cmd.load_run = 1'b1;
                                    fin_next     = s_axis_tlast;
                                    state_next   = ST_RUN;
                                end else if (s_axis_tlast) begin
                                    state_next = ST_FIN;
                                end
                            end else if (stat.marker && !s_axis_tlast) begin
                                cmd.set_pending = 1'b1;
                            end else begin
                                cmd.place_en = 1'b1;
                                if (s_axis_tlast) begin
                                    state_next = ST_FIN;
                                end
                            end
                        end else if (s_axis_tlast) begin
                            state_next = ST_FIN;
                        end
                    end
                end
            end
            ST_RUN: begin
                if (stat.issue_ok) begin
                    cmd.place_en = 1'b1;
                    cmd.sel_run  = 1'b1;
                    cmd.dec_run  = 1'b1;
                    if (stat.run_last) begin
                        state_next = fin_reg ? ST_FIN : ST_IDLE;
                    end
                end
            end
            ST_FIN: begin
                if (stat.issue_ok) begin
                    cmd.status_en = !stat.full;
                    cmd.clear_pos = 1'b1;
                    fin_next      = 1'b0;
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

/* hdl/pcxrle_dp.sv */
`timescale 1ns / 1ps

module pcxrle_dp
    import pcxrle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic [IN_DATA_W-1:0]  in_data,
    input  pcxrle_cmd_t           cmd,
    output pcxrle_stat_t          stat,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    output logic                  m_axis_tuser
);

    // configuration
    logic [DIM_BITS:0]   width_reg;
    logic [DIM_BITS:0]   height_reg;
    logic [DIM_BITS-1:0] stride_reg;
    logic                tz_reg;

    // position and run state
    logic [DIM_BITS-1:0] col_reg;
    logic [DIM_BITS:0]   row_reg;
    logic                full_reg;
    logic                pending_reg;
    logic [RUN_W-1:0]    run_len_reg;
    logic [RUN_W-1:0]    run_cnt_reg;
    logic [7:0]          run_val_reg;

    // lookup stage and output register
    logic                l_valid_reg;
    logic [7:0]          l_idx_reg;
    logic                l_last_reg;
    logic                l_short_reg;
    logic                l_inrange_reg;
    logic                l_pv_reg;
    logic                o_valid_reg;
    logic [OUT_DATA_W-1:0] o_data_reg;
    logic                o_last_reg;
    logic                o_short_reg;

    logic [PALETTE_DEPTH-1:0] pal_valid_reg;

    logic [7:0]          in_byte;
    logic [7:0]          in_entry;
    logic [23:0]         in_rgb;
    logic                pal_wr;
    logic [7:0]          pix_idx;
    logic                is_full;
    logic [DIM_BITS:0]   stride_ext;
    logic [DIM_BITS:0]   col_inc;
    logic [DIM_BITS+1:0] row_inc;
    logic [DIM_BITS:0]   vis;
    logic                visible;
    logic                pix_last;
    logic                col_wrap;
    logic                pixel_go;
    logic                issue;
    logic                o_free;
    logic                l_adv;
    logic [23:0]         ram_rdata;
    logic [23:0]         rgb;
    logic [7:0]          alpha;

    assign in_byte  = in_data[7:0];
    assign in_entry = in_data[15:8];
    assign in_rgb   = {in_data[23:16], in_data[31:24], in_data[39:32]};
    assign pal_wr   = cmd.pal_we && ({1'b0, in_entry} < PAL_DEPTH_W);

    assign stride_ext = {1'b0, stride_reg};
    assign is_full    = full_reg || (stride_reg == '0) || (row_reg >= height_reg);
    assign col_inc    = {1'b0, col_reg} + 1'b1;
    assign row_inc    = {1'b0, row_reg} + 1'b1;
    assign vis        = (width_reg < stride_ext) ? width_reg : stride_ext;
    assign visible    = {1'b0, col_reg} < width_reg;
    assign pix_last   = (row_inc == {1'b0, height_reg}) && (col_inc == vis);
    assign col_wrap   = col_inc >= stride_ext;
    assign pixel_go   = cmd.place_en && !is_full;
    assign pix_idx    = cmd.sel_run ? run_val_reg : in_byte;
    assign issue      = (pixel_go && visible) || cmd.status_en;

    assign o_free = !o_valid_reg || m_axis_tready;
    assign l_adv  = l_valid_reg && o_free;

    assign stat.issue_ok = !l_valid_reg || o_free;
    assign stat.full     = is_full;
    assign stat.pending  = pending_reg;
    assign stat.len_zero = (run_len_reg == '0);
    assign stat.marker   = (in_byte & MARK_BITS) == MARK_BITS;
    assign stat.run_last = (run_cnt_reg == RUN_W'(1));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= CFG_W'(1);
            height_reg <= CFG_W'(1);
            stride_reg <= DIM_BITS'(1);
            tz_reg     <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                CFG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                CFG_LINE_STRIDE:  stride_reg <= cfg_wdata[DIM_BITS-1:0];
                CFG_TRANSPARENT:  tz_reg     <= cfg_wdata[0];
                default:          tz_reg     <= tz_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg     <= '0;
            row_reg     <= '0;
            full_reg    <= 1'b0;
            pending_reg <= 1'b0;
            run_len_reg <= '0;
            run_cnt_reg <= '0;
        end else if (cmd.clear_pos) begin
            col_reg     <= '0;
            row_reg     <= '0;
            full_reg    <= 1'b0;
            pending_reg <= 1'b0;
            run_len_reg <= '0;
            run_cnt_reg <= '0;
        end else begin
            if (pixel_go) begin
                if (col_wrap) begin
                    col_reg <= '0;
                    row_reg <= row_inc[DIM_BITS:0];
                    if (row_inc[DIM_BITS:0] >= height_reg) begin
                        full_reg <= 1'b1;
                    end
                end else begin
                    col_reg <= col_inc[DIM_BITS-1:0];
                end
            end
            if (cmd.set_pending) begin
                pending_reg <= 1'b1;
                run_len_reg <= in_byte[RUN_W-1:0];
            end else if (cmd.clr_pending) begin
                pending_reg <= 1'b0;
                run_len_reg <= '0;
            end
            if (cmd.load_run) begin
                run_cnt_reg <= run_len_reg;
            end else if (cmd.dec_run) begin
                run_cnt_reg <= run_cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_run) begin
            run_val_reg <= in_byte;
        end
    end

    // entries never written read back as the grayscale ramp
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pal_valid_reg <= '0;
        end else if (pal_wr) begin
            pal_valid_reg[in_entry[PAL_AW-1:0]] <= 1'b1;
        end
    end

    pcxrle_ram #(
        .WIDTH (24),
        .DEPTH (PALETTE_DEPTH)
    ) u_palette (
        .aclk  (aclk),
        .we    (pal_wr),
        .waddr (in_entry[PAL_AW-1:0]),
        .wdata (in_rgb),
        .re    (issue),
        .raddr (pix_idx[PAL_AW-1:0]),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            l_valid_reg <= 1'b0;
            o_valid_reg <= 1'b0;
        end else begin
            if (issue) begin
                l_valid_reg <= 1'b1;
            end else if (l_adv) begin
                l_valid_reg <= 1'b0;
            end
            if (l_adv) begin
                o_valid_reg <= 1'b1;
            end else if (m_axis_tready) begin
                o_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (issue) begin
            l_idx_reg     <= cmd.status_en ? 8'd0 : pix_idx;
            l_last_reg    <= cmd.status_en ? 1'b1 : pix_last;
            l_short_reg   <= cmd.status_en;
            l_inrange_reg <= {1'b0, pix_idx} < PAL_DEPTH_W;
            l_pv_reg      <= pal_valid_reg[pix_idx[PAL_AW-1:0]];
        end
        if (l_adv) begin
            o_data_reg  <= {alpha, rgb[7:0], rgb[15:8], rgb[23:16], l_idx_reg};
            o_last_reg  <= l_last_reg;
            o_short_reg <= l_short_reg;
        end
    end

    always_comb begin
        if (l_short_reg || !l_inrange_reg) begin
            rgb = '0;
        end else if (l_pv_reg) begin
            rgb = ram_rdata;
        end else begin
            rgb = {l_idx_reg, l_idx_reg, l_idx_reg};
        end
        if (l_short_reg || (tz_reg && (l_idx_reg == 8'd0))) begin
            alpha = ALPHA_CLEAR;
        end else begin
            alpha = ALPHA_OPAQUE;
        end
    end

    assign m_axis_tvalid = o_valid_reg;
    assign m_axis_tdata  = o_data_reg;
    assign m_axis_tlast  = o_last_reg;
    assign m_axis_tuser  = o_short_reg;

endmodule

/* hdl/pcx_rle_palette_expander_core.sv */
`timescale 1ns / 1ps
// PCX 8-bit run-length decoder with palette expansion to RGBA.
// Input stream: encoded image bytes (tuser 0) or palette entry writes
// (tuser 1); tlast marks the last encoded byte of an image. Output stream:
// one RGBA pixel per visible decoded index; tlast on the last pixel of the
// image; tuser flags a short-stream status transfer (all data zero, tlast 1)
// sent when the stream ends before the image is full.
// Configuration (width, height, stride, transparent zero) must be written through
// the cfg port while the block is idle; the block does not enforce this.
// A pixel is registered in the lookup stage (palette RAM read) after its byte or
// its run step, then in the output register.
// A literal byte or a palette write is taken on its own; a run marker is latched,
// and its value byte then holds the input while each run pixel is placed; a final
// byte is followed by a status and position clear step. One index is placed per
// cycle through the single palette read port while the lookup stage can take it.
// Reset: position and run state clear, the palette returns to the grayscale
// ramp at once (per-entry valid flags), no clearing pass.
// When the receiver stalls, the output register and the lookup stage hold
// and s_axis_tready drops once both are full.

module pcx_rle_palette_expander_core
    import pcxrle_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [1:0]            cfg_index,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // data_byte, entry_index, entry_red, entry_green, entry_blue
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    input  logic                  s_axis_tlast,
    // op
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // color_index, red, green, blue, alpha
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    output logic                  m_axis_tlast,
    // short_stream
    output logic                  m_axis_tuser
);

    pcxrle_cmd_t  cmd;
    pcxrle_stat_t stat;

    pcxrle_ctrl u_ctrl (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tlast  (s_axis_tlast),
        .s_axis_tuser  (s_axis_tuser),
        .stat          (stat),
        .cmd           (cmd)
    );

    pcxrle_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .in_data       (s_axis_tdata),
        .cmd           (cmd),
        .stat          (stat),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

/* hdl/pcxrle_checker.sv */
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcxrle_checker
    import pcxrle_pkg::*;
(
    input logic                  aclk,
    input logic                  aresetn,
    input logic                  m_axis_tvalid,
    input logic                  m_axis_tready,
    input logic [OUT_DATA_W-1:0] m_axis_tdata,
    input logic                  m_axis_tlast,
    input logic                  m_axis_tuser
);

    // stalled result holds
    `PCX_ASSERT(a_out_hold, aclk, aresetn, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) && $stable(m_axis_tuser))

    // status transfer is last and carries no color
    `PCX_ASSERT(a_status_form, aclk, aresetn, m_axis_tvalid && m_axis_tuser |-> m_axis_tlast && (m_axis_tdata == '0))

    // alpha is either clear or opaque, and clear only on index zero
    `PCX_ASSERT(a_alpha_form, aclk, aresetn, m_axis_tvalid && !m_axis_tuser |-> (m_axis_tdata[39:32] == ALPHA_OPAQUE) || ((m_axis_tdata[39:32] == ALPHA_CLEAR) && (m_axis_tdata[7:0] == 8'd0)))

    // nothing is offered right after a reset cycle
    `PCX_ASSERT_ALWAYS(a_reset_quiet, aclk, !aresetn |=> !m_axis_tvalid)

endmodule

bind pcx_rle_palette_expander_core pcxrle_checker u_checker (.*);
